FILE: src/dfec_pkg.sv
// Shared constants and helper functions for the dihedral feature edge classifier.
`timescale 1ns / 1ps
`default_nettype none
package dfec_pkg;

  localparam int COORD_W       = 24;
  localparam int TRI_W         = 60;
  localparam int VERTEX_BITS_D = 20;
  localparam int COS_W         = 16;
  localparam int SQ_W          = 2 * COORD_W;      // squared magnitude and product width
  localparam int ROOT_STEPS    = COORD_W;          // one root bit per stage
  localparam int Q_BITS        = COS_W + 1;        // quotient bits below the overflow check
  localparam int FRAC_SHIFT    = COS_W - 1;        // Q1.15 scale
  localparam int IN_DATA_W     = 6 * COORD_W + 2 * TRI_W;
  localparam int OUT_DATA_W    = 8;
  localparam logic signed [COS_W-1:0] COS_RESET = 16'sh7fff;

  function automatic logic [1:0] next_corner(input logic [1:0] k);
    logic [1:0] r;
    r = (k == 2'd2) ? 2'd0 : k + 2'd1;
    return r;
  endfunction

  // Decide the orientation flip from the nine corner-pair match bits
  // (bit i*3+j set when corner i of the first triangle equals corner j of the second).
  function automatic logic flip_of(input logic [8:0] m);
    logic [3:0] cnt;
    logic [1:0] pi0, pj0, pi1, pj1;
    logic       f;
    cnt = 4'd0;
    pi0 = 2'd0;
    pj0 = 2'd0;
    pi1 = 2'd0;
    pj1 = 2'd0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (m[i*3+j]) begin
          if (cnt == 4'd0) begin
            pi0 = 2'(i);
            pj0 = 2'(j);
          end else if (cnt == 4'd1) begin
            pi1 = 2'(i);
            pj1 = 2'(j);
          end
          cnt = cnt + 4'd1;
        end
      end
    end
    if (next_corner(pi0) == pi1) begin
      f = (next_corner(pj0) == pj1);
    end else begin
      f = (next_corner(pj1) == pj0);
    end
    return (cnt == 4'd2) && f;
  endfunction

endpackage
`default_nettype wire

FILE: src/dihedral_feature_edge_classifier_core.sv
// Top level of the dihedral feature edge classifier: a fully pipelined edge datapath.
// Throughput is one item per cycle; the whole pipeline advances together and holds
// while a finished result waits on the output, so nothing is lost or repeated.
// Depth is set by the two 24-step square-root chains and the 17-step quotient chain.
// Synchronous active-high reset clears all stage valid bits and sets the threshold
// to 32767; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module dihedral_feature_edge_classifier_core
  import dfec_pkg::*;
#(
  parameter int VERTEX_BITS = VERTEX_BITS_D
) (
  input  wire                         clk,
  input  wire                         rst,
  // Input item channel.
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: normal_a_x, normal_a_y, normal_a_z, normal_b_x, normal_b_y,
  // normal_b_z (24 bits each), tri_a_vertices, tri_b_vertices (60 bits each).
  input  wire  [IN_DATA_W-1:0]        s_axis_tdata,
  // Fields from bit 0: two_faces.
  input  wire  [0:0]                  s_axis_tuser,
  // Result item channel.
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // Fields from bit 0: sharp_edge, then zero padding.
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0: non_manifold.
  output logic [0:0]                  m_axis_tuser,
  // Threshold register write channel (cos_threshold, signed Q1.15).
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [COS_W-1:0]            cfg_data
);

  // Stage numbering: 0 products and corner matches, 1 sums, 2..25 root steps,
  // 26 denominator product, 27 quotient overflow check, 28..43 quotient bits,
  // 44 the last quotient bit and the output register.
  localparam int SQ0     = 2;
  localparam int DEN_STG = SQ0 + ROOT_STEPS;
  localparam int OVF_STG = DEN_STG + 1;
  localparam int DIV0    = OVF_STG + 1;
  localparam int OUT_STG = DIV0 + Q_BITS;
  localparam int N_STG   = OUT_STG;
  localparam int NUM_W   = SQ_W + FRAC_SHIFT;      // |dot| scaled by 2^15
  localparam int REM_W   = NUM_W + 2;              // room for the divisor shifted by 17
  localparam int EXT_W   = 64;

  typedef struct packed {
    logic              two_faces;
    logic              flip;
    logic              neg;
    logic              zero;
    logic [SQ_W-1:0]   mag;
  } side_t;

  logic en;
  logic vld [0:N_STG-1];
  side_t side [1:OUT_STG-2];
  logic signed [COS_W-1:0] cos_threshold;

  assign en            = !vld[N_STG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = vld[N_STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_threshold <= COS_RESET;
    end else if (cfg_valid) begin
      cos_threshold <= cfg_data;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N_STG; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int s = 1; s < N_STG; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // ---------------- Stage 0: the nine products and the corner compares.
  logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
  logic [EXT_W-1:0] tri_a_ext, tri_b_ext;
  assign ax = s_axis_tdata[0*COORD_W +: COORD_W];
  assign ay = s_axis_tdata[1*COORD_W +: COORD_W];
  assign az = s_axis_tdata[2*COORD_W +: COORD_W];
  assign bx = s_axis_tdata[3*COORD_W +: COORD_W];
  assign by = s_axis_tdata[4*COORD_W +: COORD_W];
  assign bz = s_axis_tdata[5*COORD_W +: COORD_W];
  // Missing high bits of corner 2 read as zero for wide vertex indices.
  assign tri_a_ext = {{(EXT_W-TRI_W){1'b0}}, s_axis_tdata[6*COORD_W +: TRI_W]};
  assign tri_b_ext = {{(EXT_W-TRI_W){1'b0}}, s_axis_tdata[6*COORD_W+TRI_W +: TRI_W]};

  logic signed [SQ_W-1:0] p_ab [0:2];
  logic signed [SQ_W-1:0] p_aa [0:2];
  logic signed [SQ_W-1:0] p_bb [0:2];
  logic [8:0] match0;
  logic       two0;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ab[0] <= ax * bx;
      p_ab[1] <= ay * by;
      p_ab[2] <= az * bz;
      p_aa[0] <= ax * ax;
      p_aa[1] <= ay * ay;
      p_aa[2] <= az * az;
      p_bb[0] <= bx * bx;
      p_bb[1] <= by * by;
      p_bb[2] <= bz * bz;
      two0    <= s_axis_tuser[0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          match0[i*3+j] <= (tri_a_ext[i*VERTEX_BITS +: VERTEX_BITS] ==
                            tri_b_ext[j*VERTEX_BITS +: VERTEX_BITS]);
        end
      end
    end
  end

  // ---------------- Stage 1: dot product, squared lengths and the orientation flip.
  logic signed [SQ_W+1:0] dot_sum;
  logic [SQ_W-1:0] rem_a [0:ROOT_STEPS];
  logic [SQ_W-1:0] res_a [0:ROOT_STEPS];
  logic [SQ_W-1:0] rem_b [0:ROOT_STEPS];
  logic [SQ_W-1:0] res_b [0:ROOT_STEPS];

  assign dot_sum = (SQ_W+2)'(p_ab[0]) + (SQ_W+2)'(p_ab[1]) + (SQ_W+2)'(p_ab[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a[0]          <= p_aa[0] + p_aa[1] + p_aa[2];
      rem_b[0]          <= p_bb[0] + p_bb[1] + p_bb[2];
      res_a[0]          <= '0;
      res_b[0]          <= '0;
      side[1].two_faces <= two0;
      side[1].flip      <= flip_of(match0);
      side[1].neg       <= dot_sum[SQ_W+1];
      side[1].zero      <= 1'b0;
      side[1].mag       <= dot_sum[SQ_W+1] ? SQ_W'(-dot_sum) : SQ_W'(dot_sum);
    end
  end

  // ---------------- Stages 2..25: digit-by-digit integer square roots, one bit a stage.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W:0] try_a, try_b;
    assign try_a = {1'b0, res_a[k]} + {1'b0, BITV};
    assign try_b = {1'b0, res_b[k]} + {1'b0, BITV};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_a[k]} >= try_a) begin
          rem_a[k+1] <= rem_a[k] - SQ_W'(try_a);
          res_a[k+1] <= (res_a[k] >> 1) + BITV;
        end else begin
          rem_a[k+1] <= rem_a[k];
          res_a[k+1] <= res_a[k] >> 1;
        end
        if ({1'b0, rem_b[k]} >= try_b) begin
          rem_b[k+1] <= rem_b[k] - SQ_W'(try_b);
          res_b[k+1] <= (res_b[k] >> 1) + BITV;
        end else begin
          rem_b[k+1] <= rem_b[k];
          res_b[k+1] <= res_b[k] >> 1;
        end
        side[SQ0+k] <= side[SQ0+k-1];
      end
    end
  end

  // ---------------- Stage 26: denominator as the product of the two roots.
  logic [SQ_W-1:0] den;
  logic [COORD_W-1:0] ma, mb;
  assign ma = res_a[ROOT_STEPS][COORD_W-1:0];
  assign mb = res_b[ROOT_STEPS][COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      den           <= ma * mb;
      side[DEN_STG] <= side[DEN_STG-1];
    end
  end

  // ---------------- Stage 27: scale the numerator and catch quotients of 2^17 and up.
  logic [SQ_W-1:0]  dvs [OVF_STG:OUT_STG-2];
  logic [REM_W-1:0] rem [OVF_STG:OUT_STG-2];
  logic [Q_BITS-1:0] quo [OVF_STG:OUT_STG-2];
  logic              ovf [OVF_STG:OUT_STG-2];
  logic [REM_W-1:0] num_s;
  assign num_s = REM_W'(side[DEN_STG].mag) << FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      dvs[OVF_STG]  <= den;
      rem[OVF_STG]  <= num_s;
      quo[OVF_STG]  <= '0;
      ovf[OVF_STG]  <= num_s >= (REM_W'(den) << Q_BITS);
      side[OVF_STG] <= {side[DEN_STG].two_faces, side[DEN_STG].flip,
                        side[DEN_STG].neg, den == '0, side[DEN_STG].mag};
    end
  end

  // ---------------- Stages 28..43: restoring division, one quotient bit a stage.
  for (genvar d = 0; d < Q_BITS; d++) begin : g_div
    localparam int SH = Q_BITS - 1 - d;
    localparam int SI = DIV0 + d;
    logic [REM_W-1:0] sub;
    assign sub = REM_W'(dvs[SI-1]) << SH;
    if (d < Q_BITS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          dvs[SI]  <= dvs[SI-1];
          ovf[SI]  <= ovf[SI-1];
          side[SI] <= side[SI-1];
          if (rem[SI-1] >= sub) begin
            rem[SI] <= rem[SI-1] - sub;
            quo[SI] <= quo[SI-1] | (Q_BITS'(1) << SH);
          end else begin
            rem[SI] <= rem[SI-1];
            quo[SI] <= quo[SI-1];
          end
        end
      end
    end else begin : g_last
      // The last quotient bit is formed inside the output stage.
      logic [Q_BITS-1:0] q_fin;
      always_comb begin
        q_fin     = quo[SI-1];
        q_fin[SH] = (rem[SI-1] >= sub);
      end

      // ---------------- Stage 44: saturate, orient, compare, and register the result.
      logic signed [Q_BITS+1:0] c_raw, c_sat, c_or;
      logic [Q_BITS-1:0] qv;
      side_t fs;
      assign fs = side[SI-1];
      always_comb begin
        qv = q_fin;
        if (fs.zero) begin
          c_raw = '0;
        end else if (fs.neg) begin
          c_raw = -$signed({2'b00, qv});
          if (ovf[SI-1] || qv > Q_BITS'(32768)) begin
            c_raw = -(Q_BITS+2)'(32768);
          end
        end else begin
          c_raw = $signed({2'b00, qv});
          if (ovf[SI-1] || qv > Q_BITS'(32767)) begin
            c_raw = (Q_BITS+2)'(32767);
          end
        end
        c_sat = c_raw;
        c_or  = fs.flip ? -c_sat : c_sat;
        if (c_or > (Q_BITS+2)'(32767)) begin
          c_or = (Q_BITS+2)'(32767);
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          m_axis_tdata <= {{(OUT_DATA_W-1){1'b0}},
                           fs.two_faces && (c_or < (Q_BITS+2)'(cos_threshold))};
          m_axis_tuser <= !fs.two_faces;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the dihedral feature edge classifier core.
`timescale 1ns / 1ps
`default_nettype none

class edge_scoreboard;
  logic [1:0] pending_q[$];  // {non_manifold, sharp_edge}
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_edge(input logic [1:0] res);
    pending_q.push_back(res);
  endfunction

  function void check_result(input logic sharp, input logic nonman);
    logic [1:0] exp;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result sharp=%0b non_manifold=%0b", $time, sharp, nonman);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (exp[0] !== sharp) begin
      $display("%0t: sharp_edge expected %0b actual %0b", $time, exp[0], sharp);
      errors++;
    end
    if (exp[1] !== nonman) begin
      $display("%0t: non_manifold expected %0b actual %0b", $time, exp[1], nonman);
      errors++;
    end
  endfunction
endclass

module tb;
  import dfec_pkg::*;

  localparam int VB = 20;
  localparam int LATENCY = 44;
  localparam int WD_LIMIT = 4000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [COS_W-1:0] cfg_data = '0;

  edge_scoreboard sb;
  logic signed [15:0] threshold;
  int idle_cycles;
  bit hold_long;
  bit stim_done;

  dihedral_feature_edge_classifier_core #(.VERTEX_BITS(VB)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clamp16(input logic signed [63:0] v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Expected {non_manifold, sharp_edge} for one edge.
  function automatic logic [1:0] classify_edge(input logic two, input logic [IN_DATA_W-1:0] d);
    logic signed [63:0] ax, ay, az, bx, by, bz, dot, c;
    logic [63:0] na, nb, den;
    logic [59:0] ta, tb;
    int pi[2], pj[2];
    int cnt;
    bit flip;
    if (!two) return 2'b10;
    ax = 64'(signed'(d[0 +: 24]));
    ay = 64'(signed'(d[24 +: 24]));
    az = 64'(signed'(d[48 +: 24]));
    bx = 64'(signed'(d[72 +: 24]));
    by = 64'(signed'(d[96 +: 24]));
    bz = 64'(signed'(d[120 +: 24]));
    ta = d[144 +: 60];
    tb = d[204 +: 60];
    dot = ax * bx + ay * by + az * bz;
    na = ax * ax + ay * ay + az * az;
    nb = bx * bx + by * by + bz * bz;
    den = int_sqrt(na) * int_sqrt(nb);
    // SV signed division truncates toward zero, as required.
    c = (den == 0) ? 0 : clamp16((dot * 32768) / $signed(den));
    cnt = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (ta[i*VB +: VB] == tb[j*VB +: VB]) begin
          if (cnt < 2) begin
            pi[cnt] = i;
            pj[cnt] = j;
          end
          cnt++;
        end
    // Only a cleanly shared edge walked the same way by both faces flips the sign.
    if (cnt == 2) begin
      if ((pi[0] + 1) % 3 == pi[1]) flip = ((pj[0] + 1) % 3 == pj[1]);
      else flip = ((pj[1] + 1) % 3 == pj[0]);
      if (flip) c = clamp16(-c);
    end
    return {1'b0, c < 64'(threshold)};
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'(signed'($urandom_range(0, 200)) - 100);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [59:0] rand_tri();
    logic [59:0] t;
    t = 60'({$urandom, $urandom});
    return t;
  endfunction

  // Second triangle sharing an edge of the first, with random orientation.
  function automatic logic [59:0] mate_tri(input logic [59:0] ta);
    logic [VB-1:0] v[3];
    int k;
    logic [VB-1:0] p, q, r;
    k = $urandom_range(0, 2);
    p = ta[k*VB +: VB];
    q = ta[((k+1)%3)*VB +: VB];
    r = VB'($urandom);
    if ($urandom_range(0, 1)) begin
      p = q;
      q = ta[k*VB +: VB];
    end
    case ($urandom_range(0, 2))
      0: begin v[0] = p; v[1] = q; v[2] = r; end
      1: begin v[0] = r; v[1] = p; v[2] = q; end
      default: begin v[0] = q; v[1] = r; v[2] = p; end
    endcase
    return {v[2], v[1], v[0]};
  endfunction

  // Valid stays high into the next item when no idle gap is drawn.
  task automatic send_edge(input logic two, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = $urandom_range(0, 10);
    if (idle_cycles > 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    s_axis_tuser <= two;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_edge(classify_edge(two, d));
  endtask

  task automatic send_random(input bit well_formed);
    logic [IN_DATA_W-1:0] d;
    logic [59:0] ta;
    for (int f = 0; f < 6; f++) d[f*24 +: 24] = rand_coord();
    if ($urandom_range(0, 3) == 0) d[72 +: 72] = d[0 +: 72];
    ta = rand_tri();
    d[144 +: 60] = ta;
    d[204 +: 60] = well_formed ? mate_tri(ta) : rand_tri();
    send_edge($urandom_range(0, 7) != 0, d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    threshold = v;
    cfg_valid <= 0;
  endtask

  // Receiver: random stalls, plus one long hold-off to fill the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[0], m_axis_tuser[0]);
      if (hold_long) begin
        hold_long <= 0;
        idle_cycles <= 200;
        m_axis_tready <= 0;
      end else if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        m_axis_tready <= (idle_cycles == 1);
      end else if (m_axis_tready && m_axis_tvalid && $urandom_range(0, 3) == 0) begin
        idle_cycles <= $urandom_range(0, 10);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Watchdog on cycles with no accepted item.
  int quiet;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || stim_done)
      quiet <= 0;
    else if (quiet >= WD_LIMIT) begin
      $display("tb failed");
      $finish;
    end else quiet <= quiet + 1;
  end

  initial begin
    logic [IN_DATA_W-1:0] d;
    logic [59:0] ta;
    logic signed [15:0] settings[5];
    settings = '{16'sh8000, 16'sh0000, 16'sh7fff, 16'sh6000, 16'shc000};
    sb = new();
    threshold = COS_RESET;
    hold_long = 0;
    stim_done = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed edges at the reset threshold.
    send_edge(0, '1);
    send_edge(0, '0);
    d = '0;
    send_edge(1, d);  // zero-length normals
    d[0 +: 24] = 24'h7fffff; d[72 +: 24] = 24'h7fffff;
    d[24 +: 24] = 24'h800000; d[96 +: 24] = 24'h800000;
    d[48 +: 24] = 24'h800000; d[120 +: 24] = 24'h800000;
    ta = {20'd3, 20'd2, 20'd1};
    d[144 +: 60] = ta;
    d[204 +: 60] = {20'd9, 20'd2, 20'd1};       // same direction: flips
    send_edge(1, d);
    d[204 +: 60] = {20'd9, 20'd1, 20'd2};       // opposite direction
    send_edge(1, d);
    d[204 +: 60] = ta;                          // three shared corners
    send_edge(1, d);
    d[204 +: 60] = {20'd7, 20'd8, 20'd9};       // no shared corner
    send_edge(1, d);
    d[204 +: 60] = {20'd7, 20'd8, 20'd1};       // one shared corner
    send_edge(1, d);
    d[144 +: 60] = '1; d[204 +: 60] = '1;
    send_edge(1, d);
    d[72 +: 24] = 24'h800001;                   // antiparallel x
    d[0 +: 24] = 24'h7fffff; d[24 +: 48] = '0; d[96 +: 48] = '0;
    d[144 +: 60] = ta; d[204 +: 60] = {20'd9, 20'd2, 20'd1};
    send_edge(1, d);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(ph < 5 ? settings[ph] : 16'($urandom));
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 10) hold_long = 1;
        send_random($urandom_range(0, 3) != 0);
      end
      drain();
    end
    stim_done = 1;
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
